[design/dljft_pkg.sv]
// ----------------------------------------------------------------------------
// dljft_pkg
// Shared constants, types and helpers for the door latch and joint friction core.
// ----------------------------------------------------------------------------
package dljft_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int STEP_BITS      = 24;
    localparam int MUL_DIGITS     = 16;
    localparam int DIV_BITS       = 88;

    localparam logic [63:0] BIG_MAG = 64'h1000_0000_0000_0000;

    localparam logic signed [31:0] LATCH_RAW    = 32'sd68629;
    localparam logic signed [31:0] FIVE_DEG_RAW = 32'sd5719;
    localparam logic signed [31:0] OPEN_MAX_RAW = 32'sd100925;
    localparam logic signed [63:0] DOOR_SPRING  = 64'sd5000;
    localparam logic signed [63:0] DOOR_DAMPER  = 64'sd100;

    localparam logic [2:0] REG_TIME_STEP       = 3'd0;
    localparam logic [2:0] REG_KNOB_STIFFNESS  = 3'd1;
    localparam logic [2:0] REG_KNOB_VISCOSITY  = 3'd2;
    localparam logic [2:0] REG_KNOB_FRICTION   = 3'd3;
    localparam logic [2:0] REG_VALVE_STIFFNESS = 3'd4;
    localparam logic [2:0] REG_VALVE_VISCOSITY = 3'd5;
    localparam logic [2:0] REG_VALVE_FRICTION  = 3'd6;

    localparam logic [23:0] RST_TIME_STEP       = 24'd16777;
    localparam logic [30:0] RST_KNOB_STIFFNESS  = 31'd1179648;
    localparam logic [30:0] RST_KNOB_VISCOSITY  = 31'd58982;
    localparam logic [30:0] RST_KNOB_FRICTION   = 31'd163840;
    localparam logic [30:0] RST_VALVE_STIFFNESS = 31'd6553600;
    localparam logic [30:0] RST_VALVE_VISCOSITY = 31'd6554;
    localparam logic [30:0] RST_VALVE_FRICTION  = 31'd327680;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_RUN   = 5'b00100,
        S_WB    = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        SP_SPRING = 4'd0,
        SP_DAMP   = 4'd1,
        SP_VEL    = 4'd2,
        SP_DEN    = 4'd3,
        SP_DV     = 4'd4,
        SP_KLAG   = 4'd5,
        SP_BLAG   = 4'd6,
        SP_TFF    = 4'd7,
        SP_LAG    = 4'd8
    } t_step;

    // saturate to a signed word of w bits
    function automatic logic signed [63:0] sat_w(input logic signed [63:0] x, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

endpackage

[design/dljft_in_if.sv]
// ----------------------------------------------------------------------------
// dljft_in_if
// Input word channel: door, knob and valve angles and door velocity.
// ----------------------------------------------------------------------------
interface dljft_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] door_angle;
    logic signed [31:0] door_velocity;
    logic signed [31:0] knob_angle;
    logic signed [31:0] valve_angle;

    modport source(output valid, door_angle, door_velocity, knob_angle, valve_angle,
                   input ready);
    modport sink(input valid, door_angle, door_velocity, knob_angle, valve_angle,
                 output ready);
endinterface

[design/dljft_out_if.sv]
// ----------------------------------------------------------------------------
// dljft_out_if
// Output word channel: door, knob and valve torques.
// ----------------------------------------------------------------------------
interface dljft_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] door_torque;
    logic signed [31:0] knob_torque;
    logic signed [31:0] valve_torque;

    modport source(output valid, door_torque, knob_torque, valve_torque, input ready);
    modport sink(input valid, door_torque, knob_torque, valve_torque, output ready);
endinterface

[design/door_latch_and_joint_friction_torque_core.sv]
// ----------------------------------------------------------------------------
// door_latch_and_joint_friction_torque_core
// Door hinge spring/damper with knob latch, plus proxy Coulomb friction on
// the knob and valve joints, computed on one shared digit-serial unit.
// ----------------------------------------------------------------------------
// Usage: one input word (door angle, door velocity, knob angle, valve angle)
// on i_item gives one output word (door, knob, valve torque) on o_result,
// both valid/ready channels. Registers are written on the cfg port; the user
// must write them only while idle, which the block itself does not enforce.
// All products and quotients run on one shared arithmetic unit: a radix-16
// shift-add multiplier and a radix-2 restoring divider, each with an issue
// and a writeback state. One word takes two multiplies for the door and, per
// joint, two divides and five multiplies. One word is in flight at a
// time; the input is ready again as soon as the result is in the output
// register, so the next word starts while that result waits to be taken.
// If the receiver stalls, a finished result waits until the output register
// frees up. Synchronous reset clears the lags and previous angles, marks the
// next word as the first step (velocity zero) and restores register defaults.
// ----------------------------------------------------------------------------
module door_latch_and_joint_friction_torque_core #(
    parameter int DATA_WIDTH = dljft_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [30:0]   i_cfg_data,
    dljft_in_if.sink      i_item,
    dljft_out_if.source   o_result
);

    dljft_pkg::t_state r_state;
    dljft_pkg::t_step  r_step;
    logic              r_joint;
    logic              r_first;
    logic [6:0]        r_cnt;
    logic              r_ovalid;

    logic [23:0] r_time_step;
    logic [30:0] r_knob_k, r_knob_b, r_knob_f, r_valve_k, r_valve_b, r_valve_f;

    logic signed [DATA_WIDTH-1:0] r_knob_lag, r_valve_lag;
    logic signed [31:0]           r_knob_prev, r_valve_prev;

    logic signed [31:0] r_q, r_dq, r_knob, r_valve;
    logic signed [63:0] r_tmp, r_v, r_d, r_ff;
    logic signed [31:0] r_door, r_kt, r_vt;
    logic signed [31:0] r_out_door, r_out_knob, r_out_valve;

    // shared arithmetic unit
    logic          r_isdiv, r_neg;
    logic [4:0]    r_sh;
    logic [63:0]   r_ma, r_mb;
    logic [127:0]  r_acc;
    logic [87:0]   r_num, r_quo;
    logic [63:0]   r_rem;

    logic signed [63:0] w_k, w_b, w_f, w_lag, w_prev, w_angle, w_t;
    logic               w_latch, w_free;
    logic signed [63:0] w_ref;
    logic signed [63:0] w_op_a, w_op_b;
    logic [4:0]         w_op_sh;
    logic               w_op_div;
    logic [67:0]        w_pp;
    logic [68:0]        w_msum;
    logic [64:0]        w_trial;
    logic [63:0]        w_shr, w_rmag;
    logic signed [63:0] w_res, w_fa, w_ffc;
    logic               w_last;
    logic               w_out_free;

    assign i_item.ready          = (r_state == dljft_pkg::S_IDLE);
    assign o_result.valid        = r_ovalid;
    assign o_result.door_torque  = r_out_door;
    assign o_result.knob_torque  = r_out_knob;
    assign o_result.valve_torque = r_out_valve;
    assign w_out_free            = !r_ovalid || o_result.ready;

    always_comb begin
        w_t     = 64'(r_time_step);
        w_k     = r_joint ? 64'(r_valve_k) : 64'(r_knob_k);
        w_b     = r_joint ? 64'(r_valve_b) : 64'(r_knob_b);
        w_f     = r_joint ? 64'(r_valve_f) : 64'(r_knob_f);
        w_lag   = r_joint ? 64'(r_valve_lag) : 64'(r_knob_lag);
        w_prev  = r_joint ? 64'(r_valve_prev) : 64'(r_knob_prev);
        w_angle = r_joint ? 64'(r_valve) : 64'(r_knob);
        w_latch = (r_knob >= -dljft_pkg::LATCH_RAW) && (r_knob <= dljft_pkg::LATCH_RAW);
        w_free  = ((r_q > 32'sd0) && (r_q <= dljft_pkg::FIVE_DEG_RAW) && !w_latch) ||
                  ((r_q > dljft_pkg::FIVE_DEG_RAW) && (r_q <= dljft_pkg::OPEN_MAX_RAW));
        w_ref   = (r_q > dljft_pkg::OPEN_MAX_RAW) ? 64'(dljft_pkg::OPEN_MAX_RAW) : 64'sd0;
    end

    // operand select for the step about to issue
    always_comb begin
        w_op_a   = 64'sd0;
        w_op_b   = 64'sd0;
        w_op_sh  = 5'd0;
        w_op_div = 1'b0;
        unique case (r_step)
            dljft_pkg::SP_SPRING: begin
                w_op_a = dljft_pkg::DOOR_SPRING;
                w_op_b = 64'(r_q) - w_ref;
            end
            dljft_pkg::SP_DAMP: begin
                w_op_a = dljft_pkg::DOOR_DAMPER;
                w_op_b = 64'(r_dq);
            end
            dljft_pkg::SP_VEL: begin
                w_op_a   = w_angle - w_prev;
                w_op_b   = w_t;
                w_op_sh  = 5'(dljft_pkg::STEP_BITS);
                w_op_div = 1'b1;
            end
            dljft_pkg::SP_DEN: begin
                w_op_a  = w_k;
                w_op_b  = w_t;
                w_op_sh = 5'(dljft_pkg::STEP_BITS);
            end
            dljft_pkg::SP_DV: begin
                w_op_a  = r_d;
                w_op_b  = r_v;
                w_op_sh = 5'(dljft_pkg::FRAC_BITS);
            end
            dljft_pkg::SP_KLAG: begin
                w_op_a  = w_k;
                w_op_b  = w_lag;
                w_op_sh = 5'(dljft_pkg::FRAC_BITS);
            end
            dljft_pkg::SP_BLAG: begin
                w_op_a  = w_b;
                w_op_b  = w_lag;
                w_op_sh = 5'(dljft_pkg::FRAC_BITS);
            end
            dljft_pkg::SP_TFF: begin
                w_op_a  = w_t;
                w_op_b  = r_ff;
                w_op_sh = 5'(dljft_pkg::STEP_BITS);
            end
            dljft_pkg::SP_LAG: begin
                w_op_a   = r_tmp;
                w_op_b   = r_d;
                w_op_sh  = 5'(dljft_pkg::FRAC_BITS);
                w_op_div = 1'b1;
            end
            default: begin
                w_op_a = 64'sd0;
            end
        endcase
    end

    // one radix-16 multiply digit, one restoring divide bit
    always_comb begin
        w_pp    = {4'b0, r_ma} * {64'b0, r_mb[3:0]};
        w_msum  = {5'b0, r_acc[127:64]} + {1'b0, w_pp};
        w_trial = {r_rem, r_num[87]} - {1'b0, r_mb};
        w_last  = r_isdiv ? (r_cnt == 7'(dljft_pkg::DIV_BITS - 1))
                          : (r_cnt == 7'(dljft_pkg::MUL_DIGITS - 1));
    end

    // result of the unit, clamped to the 2^60 bound and signed
    always_comb begin
        w_shr = r_acc[63:0] >> r_sh;
        if (r_isdiv) begin
            w_rmag = (r_quo > 88'(dljft_pkg::BIG_MAG)) ? dljft_pkg::BIG_MAG : r_quo[63:0];
        end else if (|r_acc[127:64]) begin
            w_rmag = dljft_pkg::BIG_MAG;
        end else begin
            w_rmag = (w_shr > dljft_pkg::BIG_MAG) ? dljft_pkg::BIG_MAG : w_shr;
        end
        if (r_isdiv && (r_mb == 64'd0)) begin
            w_res = 64'sd0;
        end else begin
            w_res = r_neg ? -$signed(w_rmag) : $signed(w_rmag);
        end
        w_fa  = r_tmp + w_res;
        w_ffc = (w_fa > w_f) ? w_f : ((w_fa > -w_f) ? w_fa : -w_f);
    end

    // control, configuration and joint state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dljft_pkg::S_IDLE;
            r_step       <= dljft_pkg::SP_SPRING;
            r_joint      <= 1'b0;
            r_first      <= 1'b1;
            r_cnt        <= 7'd0;
            r_ovalid     <= 1'b0;
            r_time_step  <= dljft_pkg::RST_TIME_STEP;
            r_knob_k     <= dljft_pkg::RST_KNOB_STIFFNESS;
            r_knob_b     <= dljft_pkg::RST_KNOB_VISCOSITY;
            r_knob_f     <= dljft_pkg::RST_KNOB_FRICTION;
            r_valve_k    <= dljft_pkg::RST_VALVE_STIFFNESS;
            r_valve_b    <= dljft_pkg::RST_VALVE_VISCOSITY;
            r_valve_f    <= dljft_pkg::RST_VALVE_FRICTION;
            r_knob_lag   <= '0;
            r_valve_lag  <= '0;
            r_knob_prev  <= '0;
            r_valve_prev <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dljft_pkg::REG_TIME_STEP:       r_time_step <= i_cfg_data[23:0];
                    dljft_pkg::REG_KNOB_STIFFNESS:  r_knob_k    <= i_cfg_data;
                    dljft_pkg::REG_KNOB_VISCOSITY:  r_knob_b    <= i_cfg_data;
                    dljft_pkg::REG_KNOB_FRICTION:   r_knob_f    <= i_cfg_data;
                    dljft_pkg::REG_VALVE_STIFFNESS: r_valve_k   <= i_cfg_data;
                    dljft_pkg::REG_VALVE_VISCOSITY: r_valve_b   <= i_cfg_data;
                    dljft_pkg::REG_VALVE_FRICTION:  r_valve_f   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == dljft_pkg::S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                dljft_pkg::S_IDLE: begin
                    if (i_item.valid) begin
                        r_step  <= dljft_pkg::SP_SPRING;
                        r_joint <= 1'b0;
                        r_state <= dljft_pkg::S_ISSUE;
                    end
                end
                dljft_pkg::S_ISSUE: begin
                    r_cnt   <= 7'd0;
                    r_state <= dljft_pkg::S_RUN;
                end
                dljft_pkg::S_RUN: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (w_last) begin
                        r_state <= dljft_pkg::S_WB;
                    end
                end
                dljft_pkg::S_WB: begin
                    if (r_step == dljft_pkg::SP_LAG) begin
                        if (r_joint) begin
                            r_valve_lag  <= DATA_WIDTH'(dljft_pkg::sat_w(w_res, DATA_WIDTH));
                            r_valve_prev <= r_valve;
                            r_state      <= dljft_pkg::S_OUT;
                        end else begin
                            r_knob_lag  <= DATA_WIDTH'(dljft_pkg::sat_w(w_res, DATA_WIDTH));
                            r_knob_prev <= r_knob;
                            r_joint     <= 1'b1;
                            r_step      <= dljft_pkg::SP_VEL;
                            r_state     <= dljft_pkg::S_ISSUE;
                        end
                    end else begin
                        r_step  <= dljft_pkg::t_step'(r_step + 4'd1);
                        r_state <= dljft_pkg::S_ISSUE;
                    end
                end
                dljft_pkg::S_OUT: begin
                    if (w_out_free) begin
                        r_first  <= 1'b0;
                        r_state  <= dljft_pkg::S_IDLE;
                    end
                end
                default: r_state <= dljft_pkg::S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == dljft_pkg::S_IDLE && i_item.valid) begin
            r_q     <= i_item.door_angle;
            r_dq    <= i_item.door_velocity;
            r_knob  <= i_item.knob_angle;
            r_valve <= i_item.valve_angle;
        end
        if (r_state == dljft_pkg::S_ISSUE) begin
            r_isdiv <= w_op_div;
            r_neg   <= w_op_a[63] ^ w_op_b[63];
            r_sh    <= w_op_sh;
            r_ma    <= dljft_pkg::mag(w_op_a);
            r_mb    <= dljft_pkg::mag(w_op_b);
            r_acc   <= '0;
            r_num   <= 88'(dljft_pkg::mag(w_op_a)) << w_op_sh;
            r_rem   <= '0;
            r_quo   <= '0;
        end
        if (r_state == dljft_pkg::S_RUN) begin
            if (r_isdiv) begin
                r_num <= {r_num[86:0], 1'b0};
                if (!w_trial[64]) begin
                    r_rem <= w_trial[63:0];
                    r_quo <= {r_quo[86:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], r_num[87]};
                    r_quo <= {r_quo[86:0], 1'b0};
                end
            end else begin
                r_acc <= {w_msum[67:0], r_acc[63:4]};
                r_mb  <= r_mb >> 4;
            end
        end
        if (r_state == dljft_pkg::S_WB) begin
            case (r_step)
                dljft_pkg::SP_SPRING: r_tmp <= w_res;
                dljft_pkg::SP_DAMP: begin
                    if (w_free) begin
                        r_door <= 32'(dljft_pkg::sat_w(-64'(r_dq), 32));
                    end else begin
                        r_door <= 32'(dljft_pkg::sat_w(-r_tmp - w_res, 32));
                    end
                end
                dljft_pkg::SP_VEL:
                    r_v <= r_first ? 64'sd0 : dljft_pkg::sat_w(w_res, DATA_WIDTH);
                dljft_pkg::SP_DEN:  r_d   <= w_res + w_b;
                dljft_pkg::SP_DV:   r_tmp <= w_res;
                dljft_pkg::SP_KLAG: r_ff  <= w_ffc;
                dljft_pkg::SP_BLAG: r_tmp <= w_res;
                dljft_pkg::SP_TFF:  r_tmp <= r_tmp + w_res;
                dljft_pkg::SP_LAG: begin
                    if (r_joint) begin
                        r_vt <= 32'(dljft_pkg::sat_w(-r_ff, 32));
                    end else begin
                        r_kt <= 32'(dljft_pkg::sat_w(-r_ff, 32));
                    end
                end
                default: ;
            endcase
        end
        if (r_state == dljft_pkg::S_OUT && w_out_free) begin
            r_out_door  <= r_door;
            r_out_knob  <= r_kt;
            r_out_valve <= r_vt;
        end
    end

endmodule

[design/dljft_checker.sv]
// ----------------------------------------------------------------------------
// dljft_checker
// Port-level checks on the door latch and joint friction core.
// ----------------------------------------------------------------------------
module dljft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [95:0] i_out_word
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // one word in flight: input closes after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accept");

    // a result never shows up right after an accept while no result is waiting
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared one cycle after accept");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_word)))
        else $error("stalled output word changed");

endmodule

bind door_latch_and_joint_friction_torque_core dljft_checker u_dljft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_word  ({o_result.door_torque, o_result.knob_torque, o_result.valve_torque})
);
